@@ rtl/fpa_pkg.sv @@
// shared types and constants for the q24.8 fixed-point alu
// no dependencies; imported by fixed_point_alu
`default_nettype none

package fpa_pkg;

  // number format
  localparam int DATA_W        = 32;
  localparam int FRACTION_BITS = 8;
  // widened dividend and quotient width of the divider
  localparam int DIV_W         = DATA_W + FRACTION_BITS;

  // operation codes
  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_INC      = 4'd10,
    OP_DEC      = 4'd11,
    OP_MIN      = 4'd12,
    OP_MAX      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_kind_t;

  // input transaction
  typedef struct packed {
    op_kind_t                  kind;
    logic signed [DATA_W-1:0]  operand_a;
    logic signed [DATA_W-1:0]  operand_b;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0]  result_value;
    logic                      compare_flag;
    logic                      divide_error;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/fixed_point_alu.sv @@
// pipelined q24.8 fixed-point alu with a one-bit-per-stage restoring divider
// depends on fpa_pkg for the operation codes, transaction types and widths
//
// The block takes one transaction per clock while in_stall is low and
// returns one result per transaction, in order. Every operation runs
// through the same pipeline: an input register, an operand stage holding
// the 32x32 product and the simple operations, DIV_W divider stages (one
// quotient bit each, DIV_W is 32 plus the fraction bits, so 40) and the
// output register, sustaining one transaction per cycle while the skid
// register is empty. The divider, which resolves one quotient bit per
// stage, sets the depth of the pipeline. A skid register behind the output
// keeps the input open while a result waits; in_stall rises only once the skid register is full.
`default_nettype none

module fixed_point_alu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fpa_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fpa_pkg::out_item_t     out_data
);
  import fpa_pkg::*;

  // operand stage contents
  typedef struct packed {
    op_kind_t                 kind;
    logic [DATA_W-1:0]        res;
    logic                     flag;
    logic                     err;
    logic                     neg;
    logic [DATA_W-1:0]        divisor;
    logic [DIV_W-1:0]         nq;
    logic signed [2*DATA_W-1:0] prod;
  } opnd_stage_t;

  // divider stage contents: nq holds the remaining dividend bits on top
  // and the quotient bits found so far below
  typedef struct packed {
    op_kind_t                 kind;
    logic [DATA_W-1:0]        res;
    logic                     flag;
    logic                     err;
    logic                     neg;
    logic [DATA_W-1:0]        divisor;
    logic [DATA_W-1:0]        rem;
    logic [DIV_W-1:0]         nq;
  } div_stage_t;

  // one restoring division step
  function automatic div_stage_t div_step(input div_stage_t d);
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            qbit;
    div_stage_t      s;
    trial = {d.rem, d.nq[DIV_W-1]};
    diff  = trial - {1'b0, d.divisor};
    qbit  = ~diff[DATA_W];
    s     = d;
    s.rem = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    s.nq  = {d.nq[DIV_W-2:0], qbit};
    return s;
  endfunction

  // result formatting after the last divider stage
  function automatic out_item_t finish(input div_stage_t d);
    logic [DATA_W-1:0] q;
    out_item_t         o;
    q              = d.nq[DATA_W-1:0];
    o.compare_flag = d.flag;
    o.divide_error = d.err;
    if (d.err) begin
      o.result_value = '0;
    end else if (d.kind == OP_DIV) begin
      o.result_value = d.neg ? -q : q;
    end else begin
      o.result_value = d.res;
    end
    return o;
  endfunction

  logic                   adv;
  logic                   v0_r;
  in_item_t               s0_r;
  logic                   v1_r;
  opnd_stage_t            s1_r;
  opnd_stage_t            s1_nxt;
  div_stage_t             d_init;
  logic [DIV_W-1:0]       dv_r;
  div_stage_t             dp_r [DIV_W];
  out_item_t              last_res;
  logic                   out_valid_r;
  out_item_t              out_r;
  logic                   skid_valid_r;
  out_item_t              skid_r;
  logic                   take;
  logic [DATA_W-1:0]      mag_a;
  logic [DATA_W-1:0]      mag_b;

  // the whole pipeline moves while the skid register is empty
  assign adv      = ~skid_valid_r;
  assign in_stall = skid_valid_r;
  assign take     = out_valid_r & ~out_stall;

  // operand stage: product, simple operations and divider set-up
  always_comb begin
    mag_a         = s0_r.operand_a[DATA_W-1] ? -s0_r.operand_a : s0_r.operand_a;
    mag_b         = s0_r.operand_b[DATA_W-1] ? -s0_r.operand_b : s0_r.operand_b;
    s1_nxt.kind    = s0_r.kind;
    s1_nxt.res     = '0;
    s1_nxt.flag    = 1'b0;
    s1_nxt.err     = (s0_r.kind == OP_DIV) && (s0_r.operand_b == '0);
    s1_nxt.neg     = s0_r.operand_a[DATA_W-1] ^ s0_r.operand_b[DATA_W-1];
    s1_nxt.divisor = mag_b;
    s1_nxt.nq      = {mag_a, {FRACTION_BITS{1'b0}}};
    s1_nxt.prod    = (2*DATA_W)'(s0_r.operand_a) * (2*DATA_W)'(s0_r.operand_b);
    case (s0_r.kind)
      OP_ADD:      s1_nxt.res  = s0_r.operand_a + s0_r.operand_b;
      OP_SUB:      s1_nxt.res  = s0_r.operand_a - s0_r.operand_b;
      OP_GT:       s1_nxt.flag = s0_r.operand_a >  s0_r.operand_b;
      OP_LT:       s1_nxt.flag = s0_r.operand_a <  s0_r.operand_b;
      OP_GE:       s1_nxt.flag = s0_r.operand_a >= s0_r.operand_b;
      OP_LE:       s1_nxt.flag = s0_r.operand_a <= s0_r.operand_b;
      OP_EQ:       s1_nxt.flag = s0_r.operand_a == s0_r.operand_b;
      OP_NE:       s1_nxt.flag = s0_r.operand_a != s0_r.operand_b;
      OP_INC:      s1_nxt.res  = s0_r.operand_a + DATA_W'(1);
      OP_DEC:      s1_nxt.res  = s0_r.operand_a - DATA_W'(1);
      OP_MIN:      s1_nxt.res  = (s0_r.operand_a < s0_r.operand_b) ?
                                 s0_r.operand_a : s0_r.operand_b;
      OP_MAX:      s1_nxt.res  = (s0_r.operand_a > s0_r.operand_b) ?
                                 s0_r.operand_a : s0_r.operand_b;
      OP_FROM_INT: s1_nxt.res  = s0_r.operand_a <<< FRACTION_BITS;
      OP_TO_INT:   s1_nxt.res  = s0_r.operand_a >>> FRACTION_BITS;
      default:     s1_nxt.res  = '0;
    endcase
  end

  // entry into the divider; the product is scaled and folded in here
  always_comb begin
    d_init.kind    = s1_r.kind;
    d_init.res     = (s1_r.kind == OP_MUL) ?
                     s1_r.prod[FRACTION_BITS+DATA_W-1:FRACTION_BITS] : s1_r.res;
    d_init.flag    = s1_r.flag;
    d_init.err     = s1_r.err;
    d_init.neg     = s1_r.neg;
    d_init.divisor = s1_r.divisor;
    d_init.rem     = '0;
    d_init.nq      = s1_r.nq;
  end

  assign last_res = finish(dp_r[DIV_W-1]);

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      dv_r <= '0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      dv_r <= {dv_r[DIV_W-2:0], v1_r};
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r     <= in_data;
      s1_r     <= s1_nxt;
      dp_r[0]  <= div_step(d_init);
      for (int i = 1; i < DIV_W; i++) begin
        dp_r[i] <= div_step(dp_r[i-1]);
      end
    end
  end

  // output and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (dv_r[DIV_W-1]) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (dv_r[DIV_W-1]) begin
      if (out_valid_r && !take) begin
        skid_r <= last_res;
      end else begin
        out_r <= last_res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // skid register only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a transaction while output is empty");

  // a full skid register freezes the last divider stage
  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |=> (dv_r[DIV_W-1] == $past(dv_r[DIV_W-1])))
    else $error("pipeline moved while skid register was full");

  // a divide error always comes with a zero result and no comparison flag
  a_div_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.divide_error) |->
      (out_r.result_value == '0 && !out_r.compare_flag))
    else $error("divide error with non-zero result or flag");

endmodule

`default_nettype wire
